[hdl/cosine_similarity_check_defines.svh]
// assertion macros for the cosine similarity checker
// used by the checker bound to the top level; no other dependencies
`ifndef COSINE_SIMILARITY_CHECK_DEFINES_SVH
`define COSINE_SIMILARITY_CHECK_DEFINES_SVH

// checked after reset has been released
`define CSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/csc_pkg.sv]
// shared types and constants of the cosine similarity checker
// used by every module of the block but csc_queue; no dependencies
package csc_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned CHUNK_BITS      = 28;
  localparam int unsigned FRAC_STEPS      = 16;

  localparam logic signed [15:0] THRESHOLD_RESET = 16'sd32440;
  localparam logic signed [15:0] Q15_MAX         = 16'sh7fff;
  localparam logic signed [15:0] Q15_MIN         = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] cosine_value;
    logic               below_threshold;
    logic               zero_norm;
  } out_item_t;

endpackage

[hdl/csc_queue.sv]
// short register queue that holds finished sums between front and back
// generic width and depth; no package dependencies
module csc_queue #(
  parameter int unsigned WIDTH    = 168,
  parameter int unsigned DEPTH    = 2,
  parameter int unsigned CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output logic [WIDTH-1:0]    data_o,
  output logic [CNT_BITS-1:0] count_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_BITS'(push_i) - CNT_BITS'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hdl/csc_front.sv]
// front end: takes element pairs, multiplies and accumulates the three sums
// depends on csc_pkg; hands finished sums to csc_queue
module csc_front
  import csc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned ACC_BITS    = 2 * SAMPLE_BITS_DEF + LENGTH_BITS_DEF,
  parameter int unsigned DEPTH       = QUEUE_DEPTH,
  parameter int unsigned CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  in_item_t              item_i,
  input  logic [CNT_BITS-1:0]   q_count_i,
  output logic                  q_push_o,
  output logic [3*ACC_BITS-1:0] q_data_o
);

  localparam int unsigned PROD_BITS = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] a_s, b_s;
  logic signed [PROD_BITS-1:0]   ab, aa, bb;
  logic signed [PROD_BITS-1:0]   ab_q, aa_q, bb_q;
  logic                          p_valid_q, p_last_q;
  logic        [ACC_BITS-1:0]    dot_q, na_q, nb_q;
  logic        [ACC_BITS-1:0]    dot_nx, na_nx, nb_nx;
  logic                          accept;
  logic                          pending;

  // only the low sample bits of each field count; wider samples sign-extend the field
  if (SAMPLE_BITS <= 16) begin : g_narrow
    assign a_s = item_i.elem_a[SAMPLE_BITS-1:0];
    assign b_s = item_i.elem_b[SAMPLE_BITS-1:0];
  end else begin : g_wide
    assign a_s = SAMPLE_BITS'(item_i.elem_a);
    assign b_s = SAMPLE_BITS'(item_i.elem_b);
  end

  assign ab = a_s * b_s;
  assign aa = a_s * a_s;
  assign bb = b_s * b_s;

  // a last pair still in the product stage has a queue slot reserved
  assign pending = p_valid_q && p_last_q;
  assign full_o  = ({1'b0, q_count_i} + (CNT_BITS + 1)'(pending))
                   >= (CNT_BITS + 1)'(DEPTH);
  assign accept  = push_i && !full_o;

  assign dot_nx = dot_q + ACC_BITS'(ab_q);
  assign na_nx  = na_q + ACC_BITS'(aa_q);
  assign nb_nx  = nb_q + ACC_BITS'(bb_q);

  assign q_push_o = pending;
  assign q_data_o = {dot_nx, na_nx, nb_nx};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      p_last_q  <= 1'b0;
      dot_q     <= '0;
      na_q      <= '0;
      nb_q      <= '0;
    end else begin
      p_valid_q <= accept;
      if (accept) begin
        p_last_q <= item_i.last_element;
      end
      if (p_valid_q) begin
        if (p_last_q) begin
          dot_q <= '0;
          na_q  <= '0;
          nb_q  <= '0;
        end else begin
          dot_q <= dot_nx;
          na_q  <= na_nx;
          nb_q  <= nb_nx;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ab_q <= ab;
      aa_q <= aa;
      bb_q <= bb;
    end
  end

endmodule

[hdl/csc_back.sv]
// back end: norm product, bit-serial square root, fractional divide, result register
// depends on csc_pkg; reads finished sums from csc_queue, holds the threshold register
module csc_back
  import csc_pkg::*;
#(
  parameter int unsigned ACC_BITS = 2 * SAMPLE_BITS_DEF + LENGTH_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic [3*ACC_BITS-1:0] q_data_i,
  output logic                  q_pop_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic signed [15:0]    cfg_data_i,
  input  logic                  pop_i,
  output logic                  empty_o,
  output out_item_t             item_o
);

  localparam int unsigned NUM_CHUNKS = (ACC_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int unsigned IDX_BITS   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned PAD_BITS   = NUM_CHUNKS * CHUNK_BITS;
  localparam int unsigned PROD_BITS  = 2 * ACC_BITS;
  localparam int unsigned STEPS      = (ACC_BITS > FRAC_STEPS) ? ACC_BITS : FRAC_STEPS;
  localparam int unsigned CNT_BITS   = $clog2(STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic [ACC_BITS-1:0]       na_q, nb_q, mag_q, root_q;
  logic                      neg_q, zero_q, ovf_q;
  logic [PROD_BITS-1:0]      prod_q;
  logic [IDX_BITS-1:0]       i_q, j_q;
  logic [ACC_BITS+1:0]       srem_q;
  logic [ACC_BITS:0]         rem_q;
  logic [15:0]               quo_q;
  logic [CNT_BITS-1:0]       cnt_q;
  logic signed [15:0]        thr_q;
  logic                      out_valid_q;
  out_item_t                 out_item_q;

  logic [ACC_BITS-1:0]       dot_in, na_in, nb_in, mag_in;
  logic [PAD_BITS-1:0]       na_pad, nb_pad;
  logic [CHUNK_BITS-1:0]     pa, pb;
  logic [2*CHUNK_BITS-1:0]   pp;
  logic [2*PAD_BITS-1:0]     addend;
  logic [ACC_BITS+1:0]       rem_sh, trial;
  logic                      sq_ge;
  logic [ACC_BITS:0]         div_t, root_ext;
  logic                      div_ge;
  logic                      ovf_now;
  logic signed [15:0]        cos;
  logic                      below;

  assign dot_in = q_data_i[3*ACC_BITS-1 -: ACC_BITS];
  assign na_in  = q_data_i[2*ACC_BITS-1 -: ACC_BITS];
  assign nb_in  = q_data_i[ACC_BITS-1:0];
  assign mag_in = dot_in[ACC_BITS-1] ? (~dot_in + 1'b1) : dot_in;

  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign cfg_ready_o = 1'b1;
  assign empty_o     = !out_valid_q;
  assign item_o      = out_item_q;

  // one partial product of the norm product per cycle
  assign na_pad = PAD_BITS'(na_q);
  assign nb_pad = PAD_BITS'(nb_q);
  assign pa     = CHUNK_BITS'(na_pad >> (int'(i_q) * CHUNK_BITS));
  assign pb     = CHUNK_BITS'(nb_pad >> (int'(j_q) * CHUNK_BITS));
  assign pp     = pa * pb;
  assign addend = (2 * PAD_BITS)'(pp) << ((int'(i_q) + int'(j_q)) * CHUNK_BITS);

  // restoring square root, two radicand bits per cycle
  assign rem_sh = {srem_q[ACC_BITS-1:0], prod_q[PROD_BITS-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  // quotient of two or more is beyond the Q1.15 range
  assign ovf_now  = ({1'b0, mag_q} >= {root_q, 1'b0});
  assign root_ext = {1'b0, root_q};
  assign div_t    = (cnt_q == '0) ? rem_q : {rem_q[ACC_BITS-1:0], 1'b0};
  assign div_ge   = (div_t >= root_ext);

  always_comb begin
    if (zero_q) begin
      cos = '0;
    end else if (ovf_q) begin
      cos = neg_q ? Q15_MIN : Q15_MAX;
    end else if (neg_q) begin
      cos = quo_q[15] ? Q15_MIN : signed'(~quo_q + 1'b1);
    end else begin
      cos = (quo_q >= 16'(Q15_MAX)) ? Q15_MAX : signed'(quo_q);
    end
    below = (cos < thr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      thr_q       <= THRESHOLD_RESET;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      // a new result may replace the one popped in the same cycle
      if ((state_q == ST_DONE) && (!out_valid_q || pop_i)) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            na_q   <= na_in;
            nb_q   <= nb_in;
            mag_q  <= mag_in;
            neg_q  <= dot_in[ACC_BITS-1];
            zero_q <= (na_in == '0) || (nb_in == '0);
            ovf_q  <= 1'b0;
            prod_q <= '0;
            i_q    <= '0;
            j_q    <= '0;
            root_q <= '0;
            srem_q <= '0;
            cnt_q  <= '0;
            state_q <= ((na_in == '0) || (nb_in == '0)) ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q <= prod_q + PROD_BITS'(addend);
          if (j_q == IDX_BITS'(NUM_CHUNKS - 1)) begin
            j_q <= '0;
            if (i_q == IDX_BITS'(NUM_CHUNKS - 1)) begin
              state_q <= ST_SQRT;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_SQRT: begin
          prod_q <= prod_q << 2;
          srem_q <= sq_ge ? (rem_sh - trial) : rem_sh;
          root_q <= {root_q[ACC_BITS-2:0], sq_ge};
          if (cnt_q == CNT_BITS'(ACC_BITS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_CHECK;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_CHECK: begin
          if (ovf_now) begin
            ovf_q   <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            rem_q   <= {1'b0, mag_q};
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= div_ge ? (div_t - root_ext) : div_t;
          quo_q <= {quo_q[14:0], div_ge};
          if (cnt_q == CNT_BITS'(FRAC_STEPS - 1)) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || pop_i) begin
            out_item_q.cosine_value    <= cos;
            out_item_q.below_threshold <= below;
            out_item_q.zero_norm       <= zero_q;
            state_q                    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/cosine_similarity_check.sv]
// Streaming cosine similarity checker. Element pairs enter through push/full at one
// transaction per clock while full is low, and are multiplied and summed in a
// two-stage front end; the pair flagged last_element closes the vector, and its
// three sums go to a short queue. The back end works on one vector at a time: a
// load, the norm product one partial product at a time, the bit-serial square root
// one root bit at a time, one overflow check and 16 divide steps, then a write-out.
// Vectors that keep the front end at least as long as the back end needs per vector
// stream without a stall; shorter ones fill the queue and then hold full high. A
// result waits in the output register until popped, the back end meanwhile starting
// on the next vector. cfg_ready_o is always high.
// Depends on csc_pkg, csc_front, csc_queue and csc_back.
module cosine_similarity_check
  import csc_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int unsigned DEPTH       = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_item_i,
  input  logic               pop,
  output logic               empty,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic signed [15:0] cfg_data_i
);

  localparam int unsigned ACC_BITS = 2 * SAMPLE_BITS + LENGTH_BITS;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic                  q_push;
  logic [3*ACC_BITS-1:0] q_wdata;
  logic                  q_pop;
  logic                  q_valid;
  logic [3*ACC_BITS-1:0] q_rdata;
  logic [CNT_BITS-1:0]   q_count;

  csc_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS),
    .DEPTH       (DEPTH),
    .CNT_BITS    (CNT_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .item_i    (in_item_i),
    .q_count_i (q_count),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  csc_queue #(
    .WIDTH    (3 * ACC_BITS),
    .DEPTH    (DEPTH),
    .CNT_BITS (CNT_BITS)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .count_o (q_count)
  );

  csc_back #(
    .ACC_BITS (ACC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

endmodule

[hdl/csc_checker.sv]
// port-level checks of cosine_similarity_check, bound to the top level
// depends on csc_pkg and cosine_similarity_check_defines.svh
`include "cosine_similarity_check_defines.svh"

module csc_checker
  import csc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               pop,
  input logic               empty,
  input out_item_t          out_item_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic signed [15:0] cfg_data_i
);

  // copy of the threshold as seen through the configuration transactions
  logic signed [15:0] thr_shadow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_shadow_q <= THRESHOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_shadow_q <= cfg_data_i;
    end
  end

  `CSC_ASSERT(a_result_held, !empty && !pop |=> !empty && $stable(out_item_o), "result dropped or changed while waiting")
  `CSC_ASSERT(a_zero_norm_cos, !empty && out_item_o.zero_norm |-> out_item_o.cosine_value == 16'sd0, "zero norm with nonzero cosine")
  `CSC_ASSERT(a_threshold_flag, !empty |-> out_item_o.below_threshold == (out_item_o.cosine_value < thr_shadow_q), "threshold flag disagrees with written threshold")
  `CSC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> empty, "result shown during reset")

endmodule

bind cosine_similarity_check csc_checker u_checker (.*);
